/* rtl/pap_pkg.sv */
`default_nettype none

package pap_pkg;

    localparam int MAX_MESSAGE_BYTES_DEF = 512;
    localparam int POS_W                 = 10;
    localparam int PREFIX_LEN            = 14;

    localparam logic [POS_W-1:0] POS_MAX     = '1;
    localparam logic [16:0]      PORT_SAT    = 17'd65536;
    localparam logic [7:0]       CHAR_SPACE  = 8'h20;
    localparam logic [7:0]       CHAR_ZERO   = 8'h30;
    localparam logic [7:0]       CHAR_NINE   = 8'h39;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_TRANSFER,
        PH_PROBE,
        PH_STREAMS,
        PH_NAME
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       source_ok;
    } beat_t;

    typedef struct packed {
        logic             peer_valid;
        logic [15:0]      xfer_port;
        logic [15:0]      prb_port;
        logic [31:0]      stream_count;
        logic [POS_W-1:0] name_offset;
        logic [POS_W-1:0] name_length;
    } verdict_t;

    // Fixed message prefix, one byte per position
    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h48;
            4'd1:    b = 8'h4C;
            4'd2:    b = 8'h49;
            4'd3:    b = 8'h4E;
            4'd4:    b = 8'h4B;
            4'd5:    b = 8'h5F;
            4'd6:    b = 8'h50;
            4'd7:    b = 8'h45;
            4'd8:    b = 8'h45;
            4'd9:    b = 8'h52;
            4'd10:   b = 8'h5F;
            4'd11:   b = 8'h56;
            4'd12:   b = 8'h32;
            4'd13:   b = 8'h20;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

/* rtl/peer_advert_parser_unit.sv */
// A last-byte beat is parsed from the input stage; its verdict is registered in
// the output register, which drives m_valid; the parse is one registered pass.
// Throughput: one byte per cycle while no last byte waits for the result slot.
// Back-pressure on m_ready stalls only last-byte beats held in the input stage.
// Reset: synchronous, active-low aresetn clears both stages and parse state.
`default_nettype none

module peer_advert_parser_unit
    import pap_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_data_byte,
    input  wire logic             s_last_byte,
    input  wire logic             s_source_ok,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_peer_valid,
    output logic [15:0]           m_xfer_port,
    output logic [15:0]           m_prb_port,
    output logic [31:0]           m_stream_count,
    output logic [POS_W-1:0]      m_name_offset,
    output logic [POS_W-1:0]      m_name_length
);

    logic     beat_valid;
    beat_t    beat;
    logic     advance;
    logic     can_load;
    logic     verdict_valid;
    verdict_t verdict;

    // Hold a last-byte beat until the result slot frees up
    assign advance = beat_valid && (!beat.last_byte || can_load);

    pap_in_stage u_in_stage (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .s_source_ok (s_source_ok),
        .advance     (advance),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    pap_parse_core #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_parse_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .beat          (beat),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    pap_out_reg u_out_reg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (verdict_valid),
        .verdict        (verdict),
        .can_load       (can_load),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peer_valid   (m_peer_valid),
        .m_xfer_port    (m_xfer_port),
        .m_prb_port     (m_prb_port),
        .m_stream_count (m_stream_count),
        .m_name_offset  (m_name_offset),
        .m_name_length  (m_name_length)
    );

endmodule

`default_nettype wire

/* rtl/pap_in_stage.sv */
`default_nettype none

module pap_in_stage
    import pap_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_last_byte,
    input  wire logic       s_source_ok,
    input  wire logic       advance,
    output logic            beat_valid,
    output beat_t           beat
);

    logic  valid_reg;
    beat_t beat_reg;

    // Take a new beat when empty or when the held one moves on this cycle
    assign s_ready    = !valid_reg || advance;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            beat_reg.data_byte <= s_data_byte;
            beat_reg.last_byte <= s_last_byte;
            beat_reg.source_ok <= s_source_ok;
        end
    end

endmodule

`default_nettype wire

/* rtl/pap_parse_core.sv */
`default_nettype none

module pap_parse_core
    import pap_pkg::*;
#(
    parameter int MAX_MESSAGE_BYTES = MAX_MESSAGE_BYTES_DEF
)
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  advance,
    input  wire beat_t beat,
    output logic       verdict_valid,
    output verdict_t   verdict
);

    localparam logic [POS_W:0] MAX_LEN = (POS_W+1)'(MAX_MESSAGE_BYTES);

    phase_t           phase_reg,      phase_next,      phase_upd;
    logic [POS_W-1:0] pos_reg,        pos_next,        pos_upd;
    logic [16:0]      xfer_reg,       xfer_next,       xfer_upd;
    logic [16:0]      probe_reg,      probe_next,      probe_upd;
    logic [31:0]      stream_reg,     stream_next,     stream_upd;
    logic             ovf_reg,        ovf_next,        ovf_upd;
    logic             seen_reg,       seen_next,       seen_upd;
    logic [POS_W-1:0] nstart_reg,     nstart_next,     nstart_upd;
    logic             failed_reg,     failed_next,     failed_upd;

    logic [POS_W:0]   msg_len;
    logic [POS_W:0]   name_len_full;
    logic             is_digit;
    logic [3:0]       digit;
    logic [19:0]      xfer_step;
    logic [19:0]      probe_step;
    logic [35:0]      stream_step;
    logic             ok;

    assign msg_len  = {1'b0, pos_reg} + (POS_W+1)'(1);
    assign is_digit = (beat.data_byte >= CHAR_ZERO) && (beat.data_byte <= CHAR_NINE);
    assign digit    = beat.data_byte[3:0];

    // acc * 10 + d as two shifted adds
    assign xfer_step   = ({3'b0, xfer_reg} << 3) + ({3'b0, xfer_reg} << 1) + 20'(digit);
    assign probe_step  = ({3'b0, probe_reg} << 3) + ({3'b0, probe_reg} << 1) + 20'(digit);
    assign stream_step = ({4'b0, stream_reg} << 3) + ({4'b0, stream_reg} << 1)
                         + 36'(digit);

    // Next state: parse the held byte
    always_comb begin
        phase_upd  = phase_reg;
        xfer_upd   = xfer_reg;
        probe_upd  = probe_reg;
        stream_upd = stream_reg;
        ovf_upd    = ovf_reg;
        seen_upd   = seen_reg;
        nstart_upd = nstart_reg;
        failed_upd = failed_reg || (msg_len > MAX_LEN);
        pos_upd    = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : pos_reg;

        if (!failed_upd) begin
            case (phase_reg)
                PH_PREFIX: begin
                    if (pos_reg >= POS_W'(PREFIX_LEN) ||
                        beat.data_byte != prefix_byte(pos_reg[3:0])) begin
                        failed_upd = 1'b1;
                    end else if (pos_reg == POS_W'(PREFIX_LEN - 1)) begin
                        phase_upd = PH_TRANSFER;
                        seen_upd  = 1'b0;
                    end
                end
                PH_TRANSFER, PH_PROBE, PH_STREAMS: begin
                    if (is_digit) begin
                        seen_upd = 1'b1;
                        if (phase_reg == PH_TRANSFER) begin
                            xfer_upd = (xfer_step > 20'(PORT_SAT)) ? PORT_SAT
                                                                   : xfer_step[16:0];
                        end else if (phase_reg == PH_PROBE) begin
                            probe_upd = (probe_step > 20'(PORT_SAT)) ? PORT_SAT
                                                                     : probe_step[16:0];
                        end else if (stream_step[35:32] != 4'd0) begin
                            ovf_upd    = 1'b1;
                            stream_upd = '1;
                        end else begin
                            stream_upd = stream_step[31:0];
                        end
                    end else if (beat.data_byte == CHAR_SPACE) begin
                        if (!seen_reg) begin
                            failed_upd = 1'b1;
                        end else begin
                            seen_upd = 1'b0;
                            if (phase_reg == PH_STREAMS) begin
                                phase_upd  = PH_NAME;
                                nstart_upd = pos_reg + POS_W'(1);
                            end else if (phase_reg == PH_TRANSFER) begin
                                phase_upd = PH_PROBE;
                            end else begin
                                phase_upd = PH_STREAMS;
                            end
                        end
                    end else begin
                        failed_upd = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        // Clear per-message state after the last beat
        if (beat.last_byte) begin
            phase_next  = PH_PREFIX;
            pos_next    = '0;
            xfer_next   = '0;
            probe_next  = '0;
            stream_next = '0;
            ovf_next    = 1'b0;
            seen_next   = 1'b0;
            nstart_next = '0;
            failed_next = 1'b0;
        end else begin
            phase_next  = phase_upd;
            pos_next    = pos_upd;
            xfer_next   = xfer_upd;
            probe_next  = probe_upd;
            stream_next = stream_upd;
            ovf_next    = ovf_upd;
            seen_next   = seen_upd;
            nstart_next = nstart_upd;
            failed_next = failed_upd;
        end
    end

    // Outputs: verdict from the updated state
    assign name_len_full = msg_len - {1'b0, nstart_upd};

    always_comb begin
        ok = !failed_upd && beat.source_ok && (phase_upd == PH_NAME) &&
             (msg_len > {1'b0, nstart_upd}) &&
             (xfer_upd != 17'd0) && !xfer_upd[16] &&
             (probe_upd != 17'd0) && !probe_upd[16] &&
             (stream_upd != 32'd0) && !ovf_upd;

        verdict_valid = advance && beat.last_byte;
        verdict       = '0;
        if (ok) begin
            verdict.peer_valid   = 1'b1;
            verdict.xfer_port    = xfer_upd[15:0];
            verdict.prb_port     = probe_upd[15:0];
            verdict.stream_count = stream_upd;
            verdict.name_offset  = nstart_upd;
            verdict.name_length  = name_len_full[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_PREFIX;
            pos_reg    <= '0;
            xfer_reg   <= '0;
            probe_reg  <= '0;
            stream_reg <= '0;
            ovf_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            nstart_reg <= '0;
            failed_reg <= 1'b0;
        end else if (advance) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            xfer_reg   <= xfer_next;
            probe_reg  <= probe_next;
            stream_reg <= stream_next;
            ovf_reg    <= ovf_next;
            seen_reg   <= seen_next;
            nstart_reg <= nstart_next;
            failed_reg <= failed_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/pap_out_reg.sv */
`default_nettype none

module pap_out_reg
    import pap_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire verdict_t         verdict,
    output logic                  can_load,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_peer_valid,
    output logic [15:0]           m_xfer_port,
    output logic [15:0]           m_prb_port,
    output logic [31:0]           m_stream_count,
    output logic [POS_W-1:0]      m_name_offset,
    output logic [POS_W-1:0]      m_name_length
);

    logic     valid_reg;
    verdict_t data_reg;

    assign can_load       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_peer_valid   = data_reg.peer_valid;
    assign m_xfer_port    = data_reg.xfer_port;
    assign m_prb_port     = data_reg.prb_port;
    assign m_stream_count = data_reg.stream_count;
    assign m_name_offset  = data_reg.name_offset;
    assign m_name_length  = data_reg.name_length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg <= verdict;
        end
    end

endmodule

`default_nettype wire

/* rtl/pap_checker.sv */
`default_nettype none

module pap_checker
    import pap_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire logic             m_peer_valid,
    input wire logic [15:0]      m_xfer_port,
    input wire logic [15:0]      m_prb_port,
    input wire logic [31:0]      m_stream_count,
    input wire logic [POS_W-1:0] m_name_offset,
    input wire logic [POS_W-1:0] m_name_length
);

    // Result beat held steady while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_peer_valid) &&
        $stable(m_xfer_port) && $stable(m_prb_port) && $stable(m_stream_count) &&
        $stable(m_name_offset) && $stable(m_name_length))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_peer_valid |-> m_xfer_port == 16'd0 && m_prb_port == 16'd0 &&
        m_stream_count == 32'd0 && m_name_offset == '0 && m_name_length == '0)
        else $error("invalid verdict carries nonzero fields");

    a_valid_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_peer_valid |-> m_xfer_port != 16'd0 && m_prb_port != 16'd0 &&
        m_stream_count != 32'd0 && m_name_length != '0 &&
        m_name_offset >= POS_W'(PREFIX_LEN + 6))
        else $error("valid verdict with out-of-range field");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind peer_advert_parser_unit pap_checker u_pap_checker (.*);

`default_nettype wire

/* tb/sv/peer_advert_checker.sv */
`timescale 1ns / 1ps

module peer_advert_checker
    import pap_pkg::*;
#(
    parameter int                      MAX_BYTES   = MAX_MESSAGE_BYTES_DEF,
    parameter logic [8*PREFIX_LEN-1:0] PREFIX_TEXT = '0
)
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_last_byte,
    input  logic             s_source_ok,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic             m_peer_valid,
    input  logic [15:0]      m_xfer_port,
    input  logic [15:0]      m_prb_port,
    input  logic [31:0]      m_stream_count,
    input  logic [POS_W-1:0] m_name_offset,
    input  logic [POS_W-1:0] m_name_length,
    output int               mismatch_total,
    output int               verdicts_owed
);

    phase_t           parse_phase;
    logic [POS_W-1:0] byte_pos;
    int unsigned      transfer_acc;
    int unsigned      probe_acc;
    longint unsigned  stream_acc;
    bit               stream_ovf;
    bit               digit_pending;
    logic [POS_W-1:0] name_pos;
    bit               advert_failed;

    verdict_t         peer_verdicts_due[$];
    verdict_t         due;
    int               mismatch_seen = 0;

    task automatic clear_advert_state();
        parse_phase   = PH_PREFIX;
        byte_pos      = '0;
        transfer_acc  = 0;
        probe_acc     = 0;
        stream_acc    = 0;
        stream_ovf    = 1'b0;
        digit_pending = 1'b0;
        name_pos      = '0;
        advert_failed = 1'b0;
    endtask

    // Port accumulators stick at one past the legal range
    function automatic int unsigned port_after_digit(input int unsigned acc,
                                                     input int unsigned digit);
        int unsigned grown;
        grown = acc * 10 + digit;
        return (grown > PORT_SAT) ? int'(PORT_SAT) : grown;
    endfunction

    task automatic parse_advert_byte(input logic [7:0] b, input logic last,
                                     input logic src_ok);
        int unsigned msg_len;
        int unsigned digit;
        bit          good;
        verdict_t    verdict;
        msg_len = byte_pos;
        msg_len = msg_len + 1;
        if (msg_len > MAX_BYTES)
            advert_failed = 1'b1;
        if (!advert_failed) begin
            if (parse_phase == PH_PREFIX) begin
                if (byte_pos >= PREFIX_LEN) begin
                    advert_failed = 1'b1;
                end else if (b != PREFIX_TEXT[8*(PREFIX_LEN-1-int'(byte_pos)) +: 8]) begin
                    advert_failed = 1'b1;
                end else if (byte_pos == PREFIX_LEN - 1) begin
                    parse_phase   = PH_TRANSFER;
                    digit_pending = 1'b0;
                end
            end else if (parse_phase != PH_NAME) begin
                if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
                    digit = 32'(b - CHAR_ZERO);
                    digit_pending = 1'b1;
                    case (parse_phase)
                        PH_TRANSFER: transfer_acc = port_after_digit(transfer_acc, digit);
                        PH_PROBE:    probe_acc = port_after_digit(probe_acc, digit);
                        default: begin
                            stream_acc = stream_acc * 10 + digit;
                            if (stream_acc > 64'hFFFF_FFFF) begin
                                stream_ovf = 1'b1;
                                stream_acc = 64'hFFFF_FFFF;
                            end
                        end
                    endcase
                end else if (b == CHAR_SPACE) begin
                    if (!digit_pending) begin
                        advert_failed = 1'b1;
                    end else begin
                        digit_pending = 1'b0;
                        if (parse_phase == PH_STREAMS) begin
                            parse_phase = PH_NAME;
                            name_pos    = byte_pos + 1'b1;
                        end else begin
                            parse_phase = phase_t'(parse_phase + 1);
                        end
                    end
                end else begin
                    advert_failed = 1'b1;
                end
            end
        end
        if (byte_pos != POS_MAX)
            byte_pos = byte_pos + 1'b1;

        if (last) begin
            good = !advert_failed && src_ok && parse_phase == PH_NAME &&
                   msg_len > name_pos &&
                   transfer_acc >= 1 && transfer_acc <= 65535 &&
                   probe_acc >= 1 && probe_acc <= 65535 &&
                   stream_acc != 0 && !stream_ovf;
            verdict = '0;
            if (good) begin
                verdict.peer_valid   = 1'b1;
                verdict.xfer_port    = transfer_acc[15:0];
                verdict.prb_port     = probe_acc[15:0];
                verdict.stream_count = stream_acc[31:0];
                verdict.name_offset  = name_pos;
                verdict.name_length  = POS_W'(msg_len - name_pos);
            end
            peer_verdicts_due = {peer_verdicts_due, verdict};
            clear_advert_state();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_advert_state();
            peer_verdicts_due.delete();
        end else begin
            // check outgoing verdicts first: a beat taken at this edge is never the one leaving
            if (m_valid && m_ready) begin
                if (peer_verdicts_due.size() == 0) begin
                    mismatch_seen++;
                    if (mismatch_seen <= 10)
                        $display("unexpected verdict beat: valid=%0d xfer=%0d probe=%0d",
                                 m_peer_valid, m_xfer_port, m_prb_port);
                end else begin
                    due = peer_verdicts_due.pop_front();
                    if (m_peer_valid !== due.peer_valid ||
                        m_xfer_port !== due.xfer_port ||
                        m_prb_port !== due.prb_port ||
                        m_stream_count !== due.stream_count ||
                        m_name_offset !== due.name_offset ||
                        m_name_length !== due.name_length) begin
                        mismatch_seen++;
                        if (mismatch_seen <= 10) begin
                            $write("verdict mismatch (valid/xfer/probe/streams/off/len):");
                            $write(" expected %0d/%0d/%0d/%0d/%0d/%0d",
                                   due.peer_valid, due.xfer_port, due.prb_port,
                                   due.stream_count, due.name_offset, due.name_length);
                            $display(" got %0d/%0d/%0d/%0d/%0d/%0d",
                                     m_peer_valid, m_xfer_port, m_prb_port,
                                     m_stream_count, m_name_offset, m_name_length);
                        end
                    end
                end
            end
            if (s_valid && s_ready)
                parse_advert_byte(s_data_byte, s_last_byte, s_source_ok);
        end
        mismatch_total <= mismatch_seen;
        verdicts_owed  <= peer_verdicts_due.size();
    end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import pap_pkg::*;

    // fixed 14-byte advert prefix, first byte in the top octet
    localparam logic [8*PREFIX_LEN-1:0] ADVERT_PREFIX = {
        8'h48, 8'h4C, 8'h49, 8'h4E, 8'h4B, 8'h5F, 8'h50,
        8'h45, 8'h45, 8'h52, 8'h5F, 8'h56, 8'h32, 8'h20
    };

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    logic [7:0]       s_data_byte = 8'h00;
    logic             s_last_byte = 1'b0;
    logic             s_source_ok = 1'b0;
    logic             m_ready     = 1'b0;
    logic             s_ready;
    logic             m_valid;
    logic             m_peer_valid;
    logic [15:0]      m_xfer_port;
    logic [15:0]      m_prb_port;
    logic [31:0]      m_stream_count;
    logic [POS_W-1:0] m_name_offset;
    logic [POS_W-1:0] m_name_length;

    int               mismatch_total;
    int               verdicts_owed;

    bit               quiet_run = 1'b0;
    logic [7:0]       advert_bytes[$];
    int               name_at;
    int               stream_bytes = 0;
    int               adverts_sent;
    int unsigned      roll;
    int               cut;
    logic             src;

    peer_advert_parser_unit #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES_DEF)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .s_source_ok    (s_source_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peer_valid   (m_peer_valid),
        .m_xfer_port    (m_xfer_port),
        .m_prb_port     (m_prb_port),
        .m_stream_count (m_stream_count),
        .m_name_offset  (m_name_offset),
        .m_name_length  (m_name_length)
    );

    peer_advert_checker #(
        .MAX_BYTES   (MAX_MESSAGE_BYTES_DEF),
        .PREFIX_TEXT (ADVERT_PREFIX)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .s_source_ok    (s_source_ok),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peer_valid   (m_peer_valid),
        .m_xfer_port    (m_xfer_port),
        .m_prb_port     (m_prb_port),
        .m_stream_count (m_stream_count),
        .m_name_offset  (m_name_offset),
        .m_name_length  (m_name_length),
        .mismatch_total (mismatch_total),
        .verdicts_owed  (verdicts_owed)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= quiet_run || ($urandom_range(0, 99) >= 9);
    end

    task automatic send_beat(input logic [7:0] b, input logic last, input logic src_ok);
        while (!quiet_run && $urandom_range(0, 99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        s_source_ok <= src_ok;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // source_ok only matters on the last beat; toggle it elsewhere
    task automatic send_advert(input logic src_ok);
        int last_idx;
        last_idx = advert_bytes.size() - 1;
        foreach (advert_bytes[i])
            send_beat(advert_bytes[i], i == last_idx,
                      (i == last_idx) ? src_ok : 1'($urandom_range(0, 1)));
        stream_bytes += advert_bytes.size();
    endtask

    task automatic add_byte(input logic [7:0] b);
        advert_bytes = {advert_bytes, b};
    endtask

    task automatic new_advert();
        advert_bytes.delete();
        for (int i = 0; i < PREFIX_LEN; i++)
            add_byte(ADVERT_PREFIX[8*(PREFIX_LEN-1-i) +: 8]);
    endtask

    task automatic push_number(input longint unsigned value, input int zeros);
        logic [7:0]      digits[$];
        longint unsigned rest;
        rest = value;
        repeat (zeros) add_byte(CHAR_ZERO);
        do begin
            digits.push_front(CHAR_ZERO + 8'(rest % 10));
            rest = rest / 10;
        end while (rest != 0);
        foreach (digits[i]) add_byte(digits[i]);
    endtask

    task automatic push_field(input longint unsigned value, input int zeros);
        push_number(value, zeros);
        add_byte(CHAR_SPACE);
    endtask

    task automatic push_random_bytes(input int n);
        repeat (n) add_byte(8'($urandom_range(0, 255)));
    endtask

    function automatic longint unsigned pick_port();
        roll = $urandom_range(0, 99);
        if (roll < 3)  return 0;
        if (roll < 8)  return 1;
        if (roll < 13) return 65535;
        if (roll < 16) return 65536;
        if (roll < 19) return $urandom_range(65537, 999999);
        if (roll < 21) return {$urandom(), $urandom()};
        if (roll < 55) return $urandom_range(1, 999);
        return $urandom_range(1, 65535);
    endfunction

    function automatic longint unsigned pick_streams();
        roll = $urandom_range(0, 99);
        if (roll < 2)  return 0;
        if (roll < 7)  return 64'hFFFF_FFFF;
        if (roll < 10) return 64'h1_0000_0000;
        if (roll < 13) return {$urandom(), $urandom()};
        if (roll < 25) return $urandom();
        return $urandom_range(1, 16);
    endfunction

    // skip_field drops the digits of one number field, leaving its space
    task automatic build_random_advert(input int skip_field, input int name_len);
        new_advert();
        for (int f = 0; f < 3; f++) begin
            if (f != skip_field)
                push_number((f == 2) ? pick_streams() : pick_port(),
                            ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
            add_byte(CHAR_SPACE);
        end
        name_at = advert_bytes.size();
        push_random_bytes(name_len);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // smallest legal advert, one-byte name
        new_advert(); push_field(1, 0); push_field(1, 0); push_field(1, 0);
        add_byte(8'hFF); send_advert(1'b1);
        // largest values, leading zeros, a name holding a space
        new_advert(); push_field(65535, 2); push_field(65535, 0); push_field(64'hFFFF_FFFF, 1);
        add_byte(8'h61); add_byte(CHAR_SPACE);
        add_byte(8'h62); send_advert(1'b1);
        // ports out of range: saturation, zero, long digit run
        new_advert(); push_field(65536, 0); push_field(9, 0); push_field(3, 0);
        push_random_bytes(4); send_advert(1'b1);
        new_advert(); push_field(443, 0); push_field(0, 0); push_field(3, 0);
        push_random_bytes(4); send_advert(1'b1);
        new_advert(); push_field(64'd12345678901234, 0); push_field(5, 0); push_field(2, 0);
        push_random_bytes(3); send_advert(1'b1);
        // stream count zero, then one past 32 bits
        new_advert(); push_field(20, 0); push_field(21, 0); push_field(0, 0);
        push_random_bytes(2); send_advert(1'b1);
        new_advert(); push_field(20, 0); push_field(21, 0); push_field(64'h1_0000_0000, 0);
        push_random_bytes(2); send_advert(1'b1);
        // good text, bad source address
        new_advert(); push_field(20, 0); push_field(21, 0); push_field(4, 0);
        push_random_bytes(5); send_advert(1'b0);
        // bad prefix byte
        new_advert(); advert_bytes[0] = 8'h00; push_field(20, 0); push_field(21, 0);
        push_field(4, 0); push_random_bytes(5); send_advert(1'b1);
        // stray letter in a number field
        new_advert(); push_number(80, 0); add_byte(8'h78);
        add_byte(CHAR_SPACE); push_field(2, 0); push_field(3, 0);
        push_random_bytes(3); send_advert(1'b1);
        // empty number field
        new_advert(); add_byte(CHAR_SPACE); push_field(1, 0); push_field(1, 0);
        push_random_bytes(3); send_advert(1'b1);
        // ends inside a number field, then right at the name start
        new_advert(); push_field(80, 0); push_number(81, 0); send_advert(1'b1);
        new_advert(); push_field(1, 0); push_field(1, 0); push_field(1, 0); send_advert(1'b1);
        // prefix alone, then a lone byte
        new_advert(); send_advert(1'b1);
        advert_bytes.delete(); add_byte(8'h00); send_advert(1'b1);
        // exactly at the size limit, then one byte over
        new_advert(); push_field(1, 0); push_field(1, 0); push_field(1, 0);
        push_random_bytes(MAX_MESSAGE_BYTES_DEF - advert_bytes.size()); send_advert(1'b1);
        new_advert(); push_field(1, 0); push_field(1, 0); push_field(1, 0);
        push_random_bytes(MAX_MESSAGE_BYTES_DEF + 1 - advert_bytes.size()); send_advert(1'b1);

        adverts_sent = 0;
        while (stream_bytes < 1900) begin
            adverts_sent++;
            if (adverts_sent == 3)
                quiet_run <= 1'b1;
            else if (adverts_sent == 10)
                quiet_run <= 1'b0;
            src = ($urandom_range(0, 19) != 0);
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
                build_random_advert(-1, $urandom_range(1, 24));
            end else if (roll < 77) begin
                build_random_advert(-1, $urandom_range(1, 12));
                advert_bytes[$urandom_range(0, PREFIX_LEN - 1)] ^= 8'($urandom_range(1, 255));
            end else if (roll < 83) begin
                build_random_advert(-1, $urandom_range(1, 12));
                advert_bytes[$urandom_range(PREFIX_LEN, name_at - 1)] = 8'($urandom_range(0, 255));
            end else if (roll < 88) begin
                build_random_advert($urandom_range(0, 2), $urandom_range(1, 12));
            end else if (roll < 93) begin
                build_random_advert(-1, $urandom_range(1, 12));
                cut = $urandom_range(1, name_at);
                while (advert_bytes.size() > cut) void'(advert_bytes.pop_back());
            end else if (roll < 97) begin
                advert_bytes.delete();
                push_random_bytes($urandom_range(1, 40));
            end else if (roll < 99) begin
                build_random_advert(-1, 0);
                push_random_bytes($urandom_range(505, 520) - advert_bytes.size());
            end else begin
                // run past the position counter's top
                build_random_advert(-1, 0);
                push_random_bytes($urandom_range(1020, 1040) - advert_bytes.size());
            end
            send_advert(src);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (verdicts_owed != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_total == 0 && verdicts_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
